// File: sv/mrfp_pkg.sv
// ----------------------------------------------------------------------------
// mrfp_pkg: shared types and constants of the meter reply frame parser
// Holds the frame byte codes, status codes, parser phases and the result
// record that the parser core hands to the top level.
// ----------------------------------------------------------------------------
package mrfp_pkg;

  // Frame byte codes
  localparam logic [7:0] StartByte   = 8'h68;
  localparam logic [7:0] OffsetByte  = 8'h33;
  localparam logic [7:0] CtrlReadOk  = 8'h91;
  localparam logic [7:0] CtrlReadErr = 8'hD1;
  localparam logic [7:0] CtrlWriteOk = 8'h94;
  localparam logic [7:0] CtrlWriteErr = 8'hD4;

  // Address and identifier lengths in bytes
  localparam logic [7:0] AddrBytes = 8'd6;
  localparam logic [7:0] IdBytes   = 8'd4;

  // Result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindReport  = 1'b1;

  // Configuration register indexes
  localparam logic CfgMeterAddress   = 1'b0;
  localparam logic CfgDataIdentifier = 1'b1;

  // End-of-frame status codes
  typedef enum logic [2:0] {
    StReadOk       = 3'd0,
    StReadRefused  = 3'd1,
    StWriteOk      = 3'd2,
    StWriteRefused = 3'd3,
    StChecksumBad  = 3'd4,
    StIdMismatch   = 3'd5,
    StUnknownCtrl  = 3'd6
  } status_e;

  // Parser phases, one-hot
  typedef enum logic [7:0] {
    PhWait  = 8'b0000_0001,
    PhAddr  = 8'b0000_0010,
    PhHead2 = 8'b0000_0100,
    PhCtrl  = 8'b0000_1000,
    PhLen   = 8'b0001_0000,
    PhData  = 8'b0010_0000,
    PhCsum  = 8'b0100_0000,
    PhEnd   = 8'b1000_0000
  } phase_e;

  // One result of a parser step
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic       is_write;
    logic       success;
    logic       address_match;
    logic [7:0] control_code;
    logic [7:0] error_code;
  } result_t;

endpackage

// File: sv/meter_reply_frame_parser.sv
// ----------------------------------------------------------------------------
// meter_reply_frame_parser: byte-serial parser for meter reply frames
// Strips wake-up bytes, checks address, checksum and data identifier, and
// emits value bytes of a read reply followed by one end-of-frame report.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i, in_stall_o, in_byte_i) takes one received
//   byte per request. Output channel (out_valid_o, out_stall_i and the field
//   ports) carries value bytes (kind_o = 0) and one report per frame
//   (kind_o = 1) on the end byte. Bytes that cause no result are consumed
//   silently.
//   Configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i,
//   cfg_data_i) writes the meter address (index 0, 48 bits) or the data
//   identifier (index 1, low 32 bits); it is always ready. The user must
//   write it only while the parser is idle; the block does not enforce this.
//   An accepted byte reaches the output through the input register and
//   then the parse step into the result register. Throughput is one byte
//   per cycle while the receiver does not stall, set by the single parse
//   step between those two registers.
//   Reset clears both registers, returns the parser to waiting for a start
//   byte and sets both configuration registers to zero.
//   While the receiver stalls a waiting result, the input register holds
//   one further byte and then stalls the sender.
// ----------------------------------------------------------------------------
module meter_reply_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  status_o,
  output logic        is_write_o,
  output logic        success_o,
  output logic        address_match_o,
  output logic [7:0]  control_code_o,
  output logic [7:0]  error_code_o,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [47:0] meter_address_q;
  logic [31:0] data_identifier_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;

  logic              out_valid_q;
  mrfp_pkg::result_t out_q;
  mrfp_pkg::result_t res;

  logic out_free;
  logic step;

  // Result slot frees when empty or when its request is taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meter_address_q   <= '0;
      data_identifier_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mrfp_pkg::CfgMeterAddress:   meter_address_q   <= cfg_data_i;
        mrfp_pkg::CfgDataIdentifier: data_identifier_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Input register: take a byte whenever not stalling
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  mrfp_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .byte_i            (in_byte_q),
    .meter_address_i   (meter_address_q),
    .data_identifier_i (data_identifier_q),
    .res_o             (res)
  );

  // Result register: load on a step, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign payload_byte_o  = out_q.payload_byte;
  assign status_o        = out_q.status;
  assign is_write_o      = out_q.is_write;
  assign success_o       = out_q.success;
  assign address_match_o = out_q.address_match;
  assign control_code_o  = out_q.control_code;
  assign error_code_o    = out_q.error_code;

  // Sender is stalled only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && in_valid_q))
    else $error("meter_reply_frame_parser: stall without a held result");

  // A stalled result survives to the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("meter_reply_frame_parser: stalled result lost");

  // Success flag agrees with the reported status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == mrfp_pkg::KindReport)) |->
    (out_q.success == ((out_q.status == mrfp_pkg::StReadOk) ||
                       (out_q.status == mrfp_pkg::StWriteOk))))
    else $error("meter_reply_frame_parser: success flag disagrees with status");

  // A write reply reports a write status or a bad checksum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == mrfp_pkg::KindReport) && out_q.is_write) |->
    ((out_q.status == mrfp_pkg::StWriteOk) ||
     (out_q.status == mrfp_pkg::StWriteRefused) ||
     (out_q.status == mrfp_pkg::StChecksumBad)))
    else $error("meter_reply_frame_parser: write reply with read status");

endmodule

// File: sv/mrfp_core.sv
// ----------------------------------------------------------------------------
// mrfp_core: frame parser state and per-byte step logic
// Holds the parse phase, position counter, running sum and captured frame
// fields, and works out the result that the current byte causes.
// ----------------------------------------------------------------------------
module mrfp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic [47:0]          meter_address_i,
  input  logic [31:0]          data_identifier_i,
  output mrfp_pkg::result_t    res_o
);

  mrfp_pkg::phase_e phase_q, phase_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic       addr_ok_q, addr_ok_d;
  logic       id_ok_q, id_ok_d;
  logic [7:0] first_q, first_d;

  logic [7:0] pos_inc;
  logic [7:0] addr_byte;
  logic [7:0] id_byte;
  logic [7:0] value;
  logic [2:0] status;

  assign pos_inc   = pos_q + 8'd1;
  assign addr_byte = 8'(meter_address_i >> {pos_q[2:0], 3'b000});
  assign id_byte   = 8'(data_identifier_i >> {pos_q[1:0], 3'b000});
  assign value     = byte_i - mrfp_pkg::OffsetByte;

  // Decode the end-of-frame status from sum and control byte
  always_comb begin
    if (sum_q != 8'd0) begin
      status = mrfp_pkg::StChecksumBad;
    end else begin
      unique case (ctrl_q)
        mrfp_pkg::CtrlReadOk: begin
          status = (id_ok_q && (len_q >= mrfp_pkg::IdBytes)) ?
                   mrfp_pkg::StReadOk : mrfp_pkg::StIdMismatch;
        end
        mrfp_pkg::CtrlReadErr:  status = mrfp_pkg::StReadRefused;
        mrfp_pkg::CtrlWriteOk:  status = mrfp_pkg::StWriteOk;
        mrfp_pkg::CtrlWriteErr: status = mrfp_pkg::StWriteRefused;
        default:                status = mrfp_pkg::StUnknownCtrl;
      endcase
    end
  end

  // Advance the parser by one byte
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    len_d     = len_q;
    sum_d     = sum_q;
    ctrl_d    = ctrl_q;
    addr_ok_d = addr_ok_q;
    id_ok_d   = id_ok_q;
    first_d   = first_q;
    res_o     = '0;

    unique case (phase_q)
      mrfp_pkg::PhWait: begin
        if (byte_i == mrfp_pkg::StartByte) begin
          sum_d     = mrfp_pkg::StartByte;
          pos_d     = 8'd0;
          len_d     = 8'd0;
          ctrl_d    = 8'd0;
          addr_ok_d = 1'b1;
          id_ok_d   = 1'b1;
          first_d   = 8'd0;
          phase_d   = mrfp_pkg::PhAddr;
        end
      end
      mrfp_pkg::PhAddr: begin
        sum_d = sum_q + byte_i;
        if (byte_i != addr_byte) begin
          addr_ok_d = 1'b0;
        end
        pos_d = pos_inc;
        if (pos_inc >= mrfp_pkg::AddrBytes) begin
          phase_d = mrfp_pkg::PhHead2;
        end
      end
      mrfp_pkg::PhHead2: begin
        if (byte_i == mrfp_pkg::StartByte) begin
          sum_d   = sum_q + byte_i;
          phase_d = mrfp_pkg::PhCtrl;
        end else begin
          phase_d = mrfp_pkg::PhWait;
        end
      end
      mrfp_pkg::PhCtrl: begin
        ctrl_d  = byte_i;
        sum_d   = sum_q + byte_i;
        phase_d = mrfp_pkg::PhLen;
      end
      mrfp_pkg::PhLen: begin
        len_d   = byte_i;
        sum_d   = sum_q + byte_i;
        pos_d   = 8'd0;
        phase_d = (byte_i != 8'd0) ? mrfp_pkg::PhData : mrfp_pkg::PhCsum;
      end
      mrfp_pkg::PhData: begin
        sum_d = sum_q + byte_i;
        if (pos_q == 8'd0) begin
          first_d = byte_i;
        end
        if (ctrl_q == mrfp_pkg::CtrlReadOk) begin
          if (pos_q < mrfp_pkg::IdBytes) begin
            if (value != id_byte) begin
              id_ok_d = 1'b0;
            end
          end else if (id_ok_q) begin
            res_o.valid        = 1'b1;
            res_o.kind         = mrfp_pkg::KindPayload;
            res_o.payload_byte = value;
          end
        end
        pos_d = pos_inc;
        if (pos_inc == len_q) begin
          phase_d = mrfp_pkg::PhCsum;
        end
      end
      mrfp_pkg::PhCsum: begin
        sum_d   = sum_q ^ byte_i;
        phase_d = mrfp_pkg::PhEnd;
      end
      mrfp_pkg::PhEnd: begin
        res_o.valid         = 1'b1;
        res_o.kind          = mrfp_pkg::KindReport;
        res_o.status        = status;
        res_o.is_write      = (ctrl_q == mrfp_pkg::CtrlWriteOk) ||
                              (ctrl_q == mrfp_pkg::CtrlWriteErr);
        res_o.success       = (status == mrfp_pkg::StReadOk) ||
                              (status == mrfp_pkg::StWriteOk);
        res_o.address_match = addr_ok_q;
        res_o.control_code  = ctrl_q;
        res_o.error_code    = first_q;
        phase_d             = mrfp_pkg::PhWait;
      end
      default: begin
        phase_d = mrfp_pkg::PhWait;
      end
    endcase
  end

  // Hold parser state between bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mrfp_pkg::PhWait;
      pos_q     <= 8'd0;
      len_q     <= 8'd0;
      sum_q     <= 8'd0;
      ctrl_q    <= 8'd0;
      addr_ok_q <= 1'b1;
      id_ok_q   <= 1'b1;
      first_q   <= 8'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      sum_q     <= sum_d;
      ctrl_q    <= ctrl_d;
      addr_ok_q <= addr_ok_d;
      id_ok_q   <= id_ok_d;
      first_q   <= first_d;
    end
  end

  // The frame phase is always a single phase
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(phase_q))
    else $error("mrfp_core: phase register lost its one-hot code");

  // Position never runs past the address field while collecting it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == mrfp_pkg::PhAddr) |-> (pos_q < mrfp_pkg::AddrBytes))
    else $error("mrfp_core: address position out of range");

  // A payload byte only comes from a read reply in its data field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == mrfp_pkg::KindPayload)) |->
    ((phase_q == mrfp_pkg::PhData) && (ctrl_q == mrfp_pkg::CtrlReadOk) && id_ok_q))
    else $error("mrfp_core: payload byte outside a read reply data field");

endmodule

// File: verif/meter_reply_frame_parser_test.sv
// ----------------------------------------------------------------------------
// meter_reply_frame_parser_test: self-checking bench for the frame parser
// Sends wake-up bytes, noise and whole reply frames through the byte input.
// A predictor of its own works out each value byte and end-of-frame report,
// and a checker compares every result as the output takes it. Sender gaps,
// receiver stalls and a long hold-off of the output vary over the run.
// ----------------------------------------------------------------------------
module meter_reply_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] WakeByte = 8'hFE;
  localparam logic [7:0] EndByte = 8'h16;
  localparam int CycleLimit = 200000;
  localparam int RandomItems = 240;
  localparam int SettleCycles = 4;
  localparam int HoldOffCycles = 300;
  localparam int HoldOffValues = 40;

  // One expected result of the parser
  typedef struct packed {
    logic              kind;
    logic [7:0]        payload_byte;
    mrfp_pkg::status_e status;
    logic              is_write;
    logic              success;
    logic              address_match;
    logic [7:0]        control_code;
    logic [7:0]        error_code;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [7:0]  payload_byte_o;
  logic [2:0]  status_o;
  logic        is_write_o;
  logic        success_o;
  logic        address_match_o;
  logic [7:0]  control_code_o;
  logic [7:0]  error_code_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [47:0] cfg_data_i;

  // Predictor copy of the parser state and registers
  mrfp_pkg::phase_e prs_phase;
  logic [7:0]  prs_pos;
  logic [7:0]  prs_len;
  logic [7:0]  prs_sum;
  logic [7:0]  prs_ctrl;
  logic [7:0]  prs_first;
  logic        prs_addr_ok;
  logic        prs_id_ok;
  logic [47:0] cfg_meter_address;
  logic [31:0] cfg_identifier;

  reply_t      pending_replies[$];
  logic [7:0]  tx_bytes[$];
  logic [7:0]  data_field[$];

  int          send_idle_pct;
  int          stall_pct;
  int          hold_left;
  int          cycle_count;
  int          errors;
  int          bytes_sent;
  int          frames_built;
  int          values_checked;
  int          reports_checked;
  int          input_held;

  meter_reply_frame_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .status_o        (status_o),
    .is_write_o      (is_write_o),
    .success_o       (success_o),
    .address_match_o (address_match_o),
    .control_code_o  (control_code_o),
    .error_code_o    (error_code_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timed out after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_replies.size());
      $display("meter_reply_frame_parser verification failed");
      $finish;
    end
  end

  // Drive the output stall: hold off while the count runs, else stall at random
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  // End-of-frame status from the predictor state
  function automatic mrfp_pkg::status_e frame_status();
    if (prs_sum != 8'd0) return mrfp_pkg::StChecksumBad;
    case (prs_ctrl)
      mrfp_pkg::CtrlReadOk:
        return (prs_id_ok && prs_len >= mrfp_pkg::IdBytes) ?
               mrfp_pkg::StReadOk : mrfp_pkg::StIdMismatch;
      mrfp_pkg::CtrlReadErr:  return mrfp_pkg::StReadRefused;
      mrfp_pkg::CtrlWriteOk:  return mrfp_pkg::StWriteOk;
      mrfp_pkg::CtrlWriteErr: return mrfp_pkg::StWriteRefused;
      default:                return mrfp_pkg::StUnknownCtrl;
    endcase
  endfunction

  // Advance the predictor by one accepted byte and queue what it produces
  task automatic parse_byte(input logic [7:0] b);
    reply_t     r;
    logic [7:0] v;
    r = '0;
    v = b - mrfp_pkg::OffsetByte;
    case (prs_phase)
      mrfp_pkg::PhWait: begin
        if (b == mrfp_pkg::StartByte) begin
          prs_sum = mrfp_pkg::StartByte;
          prs_pos = '0;
          prs_len = '0;
          prs_ctrl = '0;
          prs_addr_ok = 1'b1;
          prs_id_ok = 1'b1;
          prs_first = '0;
          prs_phase = mrfp_pkg::PhAddr;
        end
      end
      mrfp_pkg::PhAddr: begin
        prs_sum = prs_sum + b;
        if (b != cfg_meter_address[8*prs_pos +: 8]) prs_addr_ok = 1'b0;
        prs_pos = prs_pos + 8'd1;
        if (prs_pos >= mrfp_pkg::AddrBytes) prs_phase = mrfp_pkg::PhHead2;
      end
      mrfp_pkg::PhHead2: begin
        if (b == mrfp_pkg::StartByte) begin
          prs_sum = prs_sum + b;
          prs_phase = mrfp_pkg::PhCtrl;
        end else begin
          prs_phase = mrfp_pkg::PhWait;
        end
      end
      mrfp_pkg::PhCtrl: begin
        prs_ctrl = b;
        prs_sum = prs_sum + b;
        prs_phase = mrfp_pkg::PhLen;
      end
      mrfp_pkg::PhLen: begin
        prs_len = b;
        prs_sum = prs_sum + b;
        prs_pos = '0;
        prs_phase = (b != 8'd0) ? mrfp_pkg::PhData : mrfp_pkg::PhCsum;
      end
      mrfp_pkg::PhData: begin
        prs_sum = prs_sum + b;
        if (prs_pos == 8'd0) prs_first = b;
        if (prs_ctrl == mrfp_pkg::CtrlReadOk) begin
          if (prs_pos < mrfp_pkg::IdBytes) begin
            if (v != cfg_identifier[8*prs_pos +: 8]) prs_id_ok = 1'b0;
          end else if (prs_id_ok) begin
            r.kind = mrfp_pkg::KindPayload;
            r.payload_byte = v;
            pending_replies.push_back(r);
          end
        end
        prs_pos = prs_pos + 8'd1;
        if (prs_pos == prs_len) prs_phase = mrfp_pkg::PhCsum;
      end
      mrfp_pkg::PhCsum: begin
        prs_sum = prs_sum ^ b;
        prs_phase = mrfp_pkg::PhEnd;
      end
      mrfp_pkg::PhEnd: begin
        r.kind = mrfp_pkg::KindReport;
        r.status = frame_status();
        r.is_write = (prs_ctrl == mrfp_pkg::CtrlWriteOk ||
                      prs_ctrl == mrfp_pkg::CtrlWriteErr);
        r.success = (r.status == mrfp_pkg::StReadOk || r.status == mrfp_pkg::StWriteOk);
        r.address_match = prs_addr_ok;
        r.control_code = prs_ctrl;
        r.error_code = prs_first;
        pending_replies.push_back(r);
        prs_phase = mrfp_pkg::PhWait;
      end
      default: begin
        prs_phase = mrfp_pkg::PhWait;
      end
    endcase
  endtask

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Check each result taken from the output against the oldest expectation
  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni && in_valid_i && in_stall_o) input_held++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, kind %0b payload %0h status %0d", $time, kind_o,
                 payload_byte_o, status_o);
      end else begin
        want = pending_replies.pop_front();
        compare_field("kind", want.kind, kind_o);
        compare_field("payload_byte", want.payload_byte, payload_byte_o);
        compare_field("status", want.status, status_o);
        compare_field("is_write", want.is_write, is_write_o);
        compare_field("success", want.success, success_o);
        compare_field("address_match", want.address_match, address_match_o);
        compare_field("control_code", want.control_code, control_code_o);
        compare_field("error_code", want.error_code, error_code_o);
        if (want.kind == mrfp_pkg::KindReport) reports_checked++;
        else values_checked++;
      end
    end
  end

  // Offer one byte after a random gap and hold it until the parser takes it
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_byte(b);
    bytes_sent++;
  endtask

  // Send every queued byte, then drop valid
  task automatic send_stream();
    foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
    tx_bytes = {};
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Wait until every expected result has come and the pipeline is empty
  task automatic wait_idle();
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [47:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == mrfp_pkg::CfgMeterAddress) cfg_meter_address = value;
    else cfg_identifier = value[31:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_registers(input logic [47:0] addr, input logic [31:0] id);
    wait_idle();
    write_reg(mrfp_pkg::CfgMeterAddress, addr);
    write_reg(mrfp_pkg::CfgDataIdentifier, {16'h0, id});
  endtask

  // Wake-up bytes and noise ahead of a frame; noise never holds a start byte
  task automatic add_preamble(input int n_wake, input int n_noise);
    repeat (n_wake) tx_bytes.push_back(WakeByte);
    repeat (n_noise) tx_bytes.push_back(mrfp_pkg::StartByte ^ 8'($urandom_range(1, 255)));
  endtask

  // Identifier bytes with the offset, optionally spoilt, then random values
  task automatic make_read_data(input logic [31:0] id, input int n_values, input bit id_bad);
    int k;
    data_field = {};
    for (int i = 0; i < 4; i++) data_field.push_back(id[8*i +: 8] + mrfp_pkg::OffsetByte);
    if (id_bad) begin
      k = $urandom_range(0, 3);
      data_field[k] = data_field[k] ^ 8'($urandom_range(1, 255));
    end
    repeat (n_values) data_field.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic make_plain_data(input int n);
    data_field = {};
    repeat (n) data_field.push_back(8'($urandom_range(0, 255)));
  endtask

  // Queue one frame around data_field; a bad second start byte ends it early
  task automatic add_frame(input logic [47:0] addr, input logic [7:0] ctrl, input bit sum_bad,
                           input bit head2_bad, input logic [7:0] end_byte);
    logic [7:0] sum;
    frames_built++;
    sum = mrfp_pkg::StartByte;
    tx_bytes.push_back(mrfp_pkg::StartByte);
    for (int i = 0; i < 6; i++) begin
      tx_bytes.push_back(addr[8*i +: 8]);
      sum = sum + addr[8*i +: 8];
    end
    if (head2_bad) begin
      tx_bytes.push_back(mrfp_pkg::StartByte ^ 8'($urandom_range(1, 255)));
      return;
    end
    tx_bytes.push_back(mrfp_pkg::StartByte);
    tx_bytes.push_back(ctrl);
    tx_bytes.push_back(8'(data_field.size()));
    sum = sum + mrfp_pkg::StartByte + ctrl + 8'(data_field.size());
    foreach (data_field[i]) begin
      tx_bytes.push_back(data_field[i]);
      sum = sum + data_field[i];
    end
    tx_bytes.push_back(sum_bad ? sum ^ 8'($urandom_range(1, 255)) : sum);
    tx_bytes.push_back(end_byte);
  endtask

  // Mostly well-formed frames with random content, some spoilt on purpose
  task automatic add_random_frame();
    logic [47:0] addr;
    logic [7:0]  ctrl;
    int          pick;
    int          k;
    int          n;
    add_preamble($urandom_range(0, 3), ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0);
    pick = $urandom_range(99);
    addr = cfg_meter_address;
    if (pick >= 88) begin
      addr = {16'($urandom), $urandom};
    end else if (pick >= 75) begin
      k = $urandom_range(0, 5);
      addr[8*k +: 8] = addr[8*k +: 8] ^ 8'($urandom_range(1, 255));
    end
    pick = $urandom_range(99);
    if (pick < 50) begin
      ctrl = mrfp_pkg::CtrlReadOk;
      n = ($urandom_range(99) < 6) ? $urandom_range(9, 60) : $urandom_range(0, 8);
      if ($urandom_range(99) < 6) make_plain_data($urandom_range(0, 3));
      else make_read_data(cfg_identifier, n, $urandom_range(99) < 15);
    end else begin
      if (pick < 60) ctrl = mrfp_pkg::CtrlReadErr;
      else if (pick < 70) ctrl = mrfp_pkg::CtrlWriteOk;
      else if (pick < 80) ctrl = mrfp_pkg::CtrlWriteErr;
      else ctrl = 8'($urandom_range(0, 255));
      make_plain_data(($urandom_range(99) < 10) ? $urandom_range(7, 24) : $urandom_range(0, 6));
    end
    add_frame(addr, ctrl, $urandom_range(99) < 10, $urandom_range(99) < 4,
              ($urandom_range(99) < 25) ? 8'($urandom_range(0, 255)) : EndByte);
  endtask

  // Registers still at their reset value: zero address and identifier
  task automatic test_reset_registers();
    make_read_data(32'h0, 2, 1'b0);
    add_frame(48'h0, mrfp_pkg::CtrlReadOk, 1'b0, 1'b0, EndByte);
    send_stream();
  endtask

  // One frame for each control code and each corner of the frame format
  task automatic test_directed_frames();
    set_registers(48'hA5_00_FF_12_68_34, 32'h00_FF_80_01);
    // wake-up bytes, noise extremes, read reply with the value extremes
    add_preamble(3, 0);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    make_read_data(cfg_identifier, 0, 1'b0);
    data_field.push_back(8'h33);
    data_field.push_back(8'h32);
    add_frame(cfg_meter_address, mrfp_pkg::CtrlReadOk, 1'b0, 1'b0, EndByte);
    // refused read with an error byte, empty write acknowledgement
    data_field = {8'h02};
    add_frame(cfg_meter_address, mrfp_pkg::CtrlReadErr, 1'b0, 1'b0, EndByte);
    data_field = {};
    add_frame(cfg_meter_address, mrfp_pkg::CtrlWriteOk, 1'b0, 1'b0, EndByte);
    // refused write whose data is a start byte
    data_field = {mrfp_pkg::StartByte};
    add_frame(cfg_meter_address, mrfp_pkg::CtrlWriteErr, 1'b0, 1'b0, EndByte);
    // bad checksum on a good read
    make_read_data(cfg_identifier, 1, 1'b0);
    add_frame(cfg_meter_address, mrfp_pkg::CtrlReadOk, 1'b1, 1'b0, EndByte);
    // read shorter than the identifier, and a wrong identifier
    data_field = {cfg_identifier[7:0] + mrfp_pkg::OffsetByte,
                  cfg_identifier[15:8] + mrfp_pkg::OffsetByte};
    add_frame(cfg_meter_address, mrfp_pkg::CtrlReadOk, 1'b0, 1'b0, EndByte);
    make_read_data(cfg_identifier, 2, 1'b1);
    add_frame(cfg_meter_address, mrfp_pkg::CtrlReadOk, 1'b0, 1'b0, EndByte);
    // unknown control with an odd end byte
    data_field = {};
    add_frame(cfg_meter_address, 8'hFF, 1'b0, 1'b0, 8'h00);
    // wrong second start byte, then wrong address on a write
    add_frame(cfg_meter_address, mrfp_pkg::CtrlReadOk, 1'b0, 1'b1, EndByte);
    data_field = {8'h55};
    add_frame(~cfg_meter_address, mrfp_pkg::CtrlWriteOk, 1'b0, 1'b0, EndByte);
    send_stream();
  endtask

  // Random frames over the idling phases, registers changed between phases
  task automatic test_random_traffic();
    int start;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          set_registers('1, '1);
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          set_registers({16'($urandom), $urandom}, $urandom);
          send_idle_pct = 86;
          stall_pct = 0;
        end
        2: begin
          set_registers('0, '0);
          send_idle_pct = 0;
          stall_pct = 86;
        end
        default: begin
          set_registers({16'($urandom), $urandom}, $urandom);
          send_idle_pct = 23;
          stall_pct = 23;
        end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < RandomItems / 4) begin
        add_random_frame();
        send_stream();
      end
    end
  endtask

  // Hold the output off while a long read reply keeps arriving
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    make_read_data(cfg_identifier, HoldOffValues, 1'b0);
    add_frame(cfg_meter_address, mrfp_pkg::CtrlReadOk, 1'b0, 1'b0, EndByte);
    hold_left = HoldOffCycles;
    send_stream();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mrfp_pkg::CfgMeterAddress;
    cfg_data_i = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    cycle_count = 0;
    errors = 0;
    bytes_sent = 0;
    frames_built = 0;
    values_checked = 0;
    reports_checked = 0;
    input_held = 0;
    prs_phase = mrfp_pkg::PhWait;
    prs_pos = '0;
    prs_len = '0;
    prs_sum = '0;
    prs_ctrl = '0;
    prs_first = '0;
    prs_addr_ok = 1'b1;
    prs_id_ok = 1'b1;
    cfg_meter_address = '0;
    cfg_identifier = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_registers();
    test_directed_frames();
    test_random_traffic();
    test_backpressure();
    wait_idle();

    $display("Parsed %0d bytes in %0d frames; %0d value bytes and %0d frame reports matched.",
             bytes_sent, frames_built, values_checked, reports_checked);
    $display("Byte input held off for %0d cycles under output stalls; %0d mismatches.",
             input_held, errors);
    if (errors == 0) begin
      $display("meter_reply_frame_parser verification clean");
    end else begin
      $display("meter_reply_frame_parser verification failed");
    end
    $finish;
  end

endmodule
